FILE: rtl/lmta_pkg.sv
// Shared types and constants for the lattice mesh triangle assembler.
// Depends on nothing; every other file of the block imports it.
package lmta_pkg;

    // Largest row the row store can hold, and the column index width it implies.
    localparam int MAX_ROW_VERTICES = 1024;
    localparam int COL_W            = $clog2(MAX_ROW_VERTICES);
    localparam int ROW_W            = COL_W + 1;

    // Width of the vertices_per_row register.
    localparam int CFG_W = 11;

    // Depth of the job queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic        [31:0] color;
    } vertex_t;

    typedef struct packed {
        logic               mesh_start;
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic        [31:0] vertex_color;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] tri_a_x;
        logic signed [31:0] tri_a_y;
        logic        [31:0] tri_a_color;
        logic signed [31:0] tri_b_x;
        logic signed [31:0] tri_b_y;
        logic        [31:0] tri_b_color;
        logic signed [31:0] tri_c_x;
        logic signed [31:0] tri_c_y;
        logic        [31:0] tri_c_color;
        logic               last_of_run;
    } out_word_t;

    // One classified vertex, as handed from the front to the back.
    typedef struct packed {
        vertex_t            vtx;
        vertex_t            left;
        logic [COL_W-1:0]   col;
        logic               last_col;
        logic               first_row;
    } job_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

endpackage

FILE: rtl/lmta_front.sv
// Front part of the assembler: holds the row width register, tracks the lattice
// position and classifies each incoming vertex into a job. Uses lmta_pkg.
module lmta_front
    import lmta_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_word_t           in_word,
    input  queue_status_t      q_status,
    output logic               push,
    output job_t               push_job
);

    logic [CFG_W-1:0] row_len_reg;
    logic [COL_W-1:0] col_reg;
    logic             first_row_reg;
    vertex_t          left_reg;

    logic [ROW_W-1:0] width;
    logic [COL_W-1:0] last_idx;
    logic [COL_W-1:0] col_raw;
    logic [COL_W-1:0] col;
    logic [COL_W-1:0] col_next;
    logic             first_row;
    logic             first_row_next;
    logic             last_col;
    vertex_t          vtx;

    // Out-of-range widths are pinned to the supported range.
    always_comb
    begin
        if (row_len_reg < CFG_W'(2))
        begin
            width = ROW_W'(2);
        end
        else if (32'(row_len_reg) > 32'(MAX_ROW_VERTICES))
        begin
            width = ROW_W'(MAX_ROW_VERTICES);
        end
        else
        begin
            width = ROW_W'(row_len_reg);
        end
    end

    always_comb
    begin
        last_idx       = COL_W'(width - ROW_W'(1));
        col_raw        = in_word.mesh_start ? '0 : col_reg;
        first_row      = in_word.mesh_start | first_row_reg;
        last_col       = (col_raw >= last_idx);
        col            = last_col ? last_idx : col_raw;
        col_next       = last_col ? '0 : col + COL_W'(1);
        first_row_next = first_row & ~last_col;
        vtx.x          = in_word.vertex_x;
        vtx.y          = in_word.vertex_y;
        vtx.color      = in_word.vertex_color;
    end

    assign cfg_ready = 1'b1;
    assign in_stall  = q_status.full;
    assign push      = in_valid & ~q_status.full;

    always_comb
    begin
        push_job.vtx       = vtx;
        push_job.left      = left_reg;
        push_job.col       = col;
        push_job.last_col  = last_col;
        push_job.first_row = first_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_reg   <= CFG_W'(2);
            col_reg       <= '0;
            first_row_reg <= 1'b1;
            left_reg      <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                row_len_reg <= cfg_data;
            end
            if (push)
            begin
                col_reg       <= col_next;
                first_row_reg <= first_row_next;
                left_reg      <= vtx;
            end
        end
    end

endmodule

FILE: rtl/lmta_queue.sv
// Short job queue that decouples the front from the back.
// Uses lmta_pkg for the job type and depth.
module lmta_queue
    import lmta_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  job_t          push_job,
    input  logic          pop,
    output queue_status_t status,
    output job_t          head_job
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign status.full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.not_empty = (count_reg != '0);
    assign head_job         = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/lmta_back.sv
// Back part of the assembler: row store, triangle formation and output register.
// Uses lmta_pkg; takes jobs from lmta_queue.
module lmta_back
    import lmta_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  queue_status_t q_status,
    input  job_t          head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output out_word_t     out_word
);

    // Previous row, one vertex per column.
    vertex_t          store_mem [MAX_ROW_VERTICES];

    vertex_t          above_reg;
    vertex_t          above_next_reg;
    job_t             job_reg;
    logic             pend1_reg;
    logic             pend2_reg;
    logic             out_valid_reg;
    out_word_t        out_word_reg;

    logic [COL_W-1:0] col_p1;
    logic             out_load;
    logic             stage_free;
    logic             has1;
    logic             has2;
    out_word_t        tri_sel;

    assign col_p1     = head_job.col + COL_W'(1);
    assign out_load   = (pend1_reg | pend2_reg) & (~out_valid_reg | ~out_stall);
    assign stage_free = ~(pend1_reg | pend2_reg) | (out_load & (pend1_reg ^ pend2_reg));
    assign pop        = q_status.not_empty & stage_free;
    assign has1       = ~head_job.first_row & (head_job.col != '0);
    assign has2       = ~head_job.first_row & ~head_job.last_col;

    always_comb
    begin
        tri_sel.tri_a_x     = above_reg.x;
        tri_sel.tri_a_y     = above_reg.y;
        tri_sel.tri_a_color = above_reg.color;
        tri_sel.tri_c_x     = job_reg.vtx.x;
        tri_sel.tri_c_y     = job_reg.vtx.y;
        tri_sel.tri_c_color = job_reg.vtx.color;
        if (pend1_reg)
        begin
            tri_sel.tri_b_x     = job_reg.left.x;
            tri_sel.tri_b_y     = job_reg.left.y;
            tri_sel.tri_b_color = job_reg.left.color;
            tri_sel.last_of_run = job_reg.last_col;
        end
        else
        begin
            tri_sel.tri_b_x     = above_next_reg.x;
            tri_sel.tri_b_y     = above_next_reg.y;
            tri_sel.tri_b_color = above_next_reg.color;
            tri_sel.last_of_run = 1'b1;
        end
    end

    // The write and both reads share one edge; the reads see the old contents.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            store_mem[head_job.col] <= head_job.vtx;
            above_reg               <= store_mem[head_job.col];
            above_next_reg          <= store_mem[col_p1];
            job_reg                 <= head_job;
        end
        if (out_load)
        begin
            out_word_reg <= tri_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend1_reg     <= 1'b0;
            pend2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pend1_reg <= has1;
                pend2_reg <= has2;
            end
            else if (out_load)
            begin
                if (pend1_reg)
                begin
                    pend1_reg <= 1'b0;
                end
                else
                begin
                    pend2_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // A first-row vertex leaves no triangle behind.
    a_first_row_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_job.first_row) |=> (!pend1_reg && !pend2_reg))
        else $error("first-row vertex produced a triangle");

    // The first of a pair of triangles is never marked as the last one.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && pend1_reg && pend2_reg) |=> !out_word_reg.last_of_run)
        else $error("first triangle of a pair marked last");

    // Row store data stays put while its triangles are still being sent.
    a_above_held: assert property (@(posedge clk) disable iff (!rst_n)
        ((pend1_reg || pend2_reg) && !pop) |=> ($stable(above_reg) && $stable(above_next_reg)))
        else $error("row store data changed under a pending triangle");

endmodule

FILE: rtl/lattice_mesh_triangle_assembler.sv
// Top level of the lattice mesh triangle assembler: front, job queue and back.
// Uses lmta_pkg, lmta_front, lmta_queue and lmta_back.

// Vertices of a lattice-form mesh arrive one word at a time in row-major order,
// and each vertex after the first row leaves up to two Gouraud triangles: first
// (above, left neighbour, vertex) unless it sits in column 0, then (above,
// above-right, vertex) unless it sits in the last column. The last triangle of
// each vertex carries last_of_run. A vertex with mesh_start set begins a new
// mesh at column 0 of a first row, and first-row vertices only fill the row
// store. vertices_per_row is written through the cfg channel, which is always
// ready; values below 2 act as 2 and values above 1024 act as 1024, and the
// register should be written only while the block is idle. The front accepts a
// vertex in any cycle in which the four-entry job queue has room, so input words
// are taken while earlier triangles still wait at the output. The back drains
// the queue through a row store of 1024 entries (one write and two reads per
// cycle) into a single output register that delivers one triangle per cycle
// while out_stall is low and so sets the sustained rate. A vertex inside a row
// yields two triangles, one in column 0 or in the last column and none in the
// first row. The first triangle of an accepted vertex passes the job queue, the
// job register and the output register before it is offered. The row store
// needs no clearing after reset: every entry a triangle uses is written first.
module lattice_mesh_triangle_assembler
    import lmta_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_word_t         in_word,
    output logic             out_valid,
    input  logic             out_stall,
    output out_word_t        out_word
);

    // Classified jobs travel from the front to the back through the queue.
    queue_status_t q_status;
    logic          push;
    logic          pop;
    job_t          push_job;
    job_t          head_job;

    lmta_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    lmta_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .status  (q_status),
        .head_job(head_job)
    );

    lmta_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head_job (head_job),
        .pop      (pop),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_word (out_word)
    );

endmodule

FILE: bench/tb_lmta_sb_pkg.sv
`timescale 1ns / 100ps
// Triangle tracker for the lattice mesh triangle assembler bench.
// Depends on lmta_pkg for the vertex, input word and output word types.
package tb_lmta_sb_pkg;

    import lmta_pkg::*;

    class mesh_triangle_tracker;

        logic [CFG_W-1:0] row_setting;
        vertex_t          row_store [MAX_ROW_VERTICES];
        bit               written   [MAX_ROW_VERTICES];
        int unsigned      column;
        bit               first_row;
        vertex_t          left_vertex;
        out_word_t        pending_triangles [$];
        int unsigned      errors;

        function new();
            row_setting = 11'd2;
            column      = 0;
            first_row   = 1'b1;
            left_vertex = '0;
            errors      = 0;
            foreach (written[k])
                written[k] = 1'b0;
        endfunction

        function void set_width(logic [CFG_W-1:0] setting);
            row_setting = setting;
        endfunction

        // Row width as the block uses it, clipped into 2..MAX_ROW_VERTICES.
        function int unsigned eff_width();
            if (row_setting < 2)
                return 2;
            if (row_setting > MAX_ROW_VERTICES)
                return MAX_ROW_VERTICES;
            return row_setting;
        endfunction

        function int unsigned pending();
            return pending_triangles.size();
        endfunction

        function out_word_t make_tri(vertex_t a, vertex_t b, vertex_t c, logic last);
            out_word_t t;
            t.tri_a_x     = a.x;
            t.tri_a_y     = a.y;
            t.tri_a_color = a.color;
            t.tri_b_x     = b.x;
            t.tri_b_y     = b.y;
            t.tri_b_color = b.color;
            t.tri_c_x     = c.x;
            t.tri_c_y     = c.y;
            t.tri_c_color = c.color;
            t.last_of_run = last;
            return t;
        endfunction

        function void note_vertex(in_word_t w);
            vertex_t     v;
            vertex_t     up;
            int unsigned wd;
            int unsigned j;
            bit          last_col;
            v.x     = w.vertex_x;
            v.y     = w.vertex_y;
            v.color = w.vertex_color;
            wd      = eff_width();
            if (w.mesh_start)
            begin
                column    = 0;
                first_row = 1'b1;
            end
            j        = column;
            last_col = (j >= wd - 1);
            if (last_col)
                j = wd - 1;
            if (!first_row)
            begin
                up = row_store[j];
                if (j > 0)
                    pending_triangles.push_back(make_tri(up, left_vertex, v, last_col));
                if (!last_col)
                    pending_triangles.push_back(make_tri(up, row_store[j + 1], v, 1'b1));
            end
            row_store[j] = v;
            written[j]   = 1'b1;
            left_vertex  = v;
            if (last_col)
            begin
                column    = 0;
                first_row = 1'b0;
            end
            else
                column = j + 1;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s: expected %h, got %h", name, want, got);
                errors++;
            end
        endfunction

        function void check_triangle(out_word_t got);
            out_word_t want;
            if (pending_triangles.size() == 0)
            begin
                $error("triangle with none outstanding: %h", got);
                errors++;
                return;
            end
            want = pending_triangles.pop_front();
            compare_field("tri_a_x", want.tri_a_x, got.tri_a_x);
            compare_field("tri_a_y", want.tri_a_y, got.tri_a_y);
            compare_field("tri_a_color", want.tri_a_color, got.tri_a_color);
            compare_field("tri_b_x", want.tri_b_x, got.tri_b_x);
            compare_field("tri_b_y", want.tri_b_y, got.tri_b_y);
            compare_field("tri_b_color", want.tri_b_color, got.tri_b_color);
            compare_field("tri_c_x", want.tri_c_x, got.tri_c_x);
            compare_field("tri_c_y", want.tri_c_y, got.tri_c_y);
            compare_field("tri_c_color", want.tri_c_color, got.tri_c_color);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

    endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Top-level bench for lattice_mesh_triangle_assembler: drives vertex words and the
// row width register, and checks every triangle word. Uses lmta_pkg and tb_lmta_sb_pkg.
module tb_top;

    import lmta_pkg::*;
    import tb_lmta_sb_pkg::*;

    // The run is ended by force after this many cycles.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    // Cycles allowed after the last triangle for a first-row vertex still in flight.
    localparam int unsigned DRAIN_CYCLES = 16;
    // Accepted vertex words after which the idling pattern changes.
    localparam int unsigned MODE_SPLIT   = 583;

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [CFG_W-1:0] cfg_data;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;

    mesh_triangle_tracker tracker;

    int unsigned cycles;
    int unsigned accepted;
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;

    lattice_mesh_triangle_assembler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung block or a lost handshake ends the run here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // The receiver stalls at random on the falling edge, so that the stall is
    // steady across the next rising edge whatever the block is doing.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Every triangle word taken at a rising edge is checked against the oldest
    // outstanding prediction. Values are read as they stood at the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_triangle(out_word);
    end

    // Mostly random words, with the four corner values of a 32-bit field mixed in
    // often enough that the sign boundaries are hit many times.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic in_word_t vtx(logic start, logic [31:0] x, logic [31:0] y,
                                     logic [31:0] c);
        in_word_t w;
        w.mesh_start   = start;
        w.vertex_x     = x;
        w.vertex_y     = y;
        w.vertex_color = c;
        return w;
    endfunction

    // Offers one vertex word from a falling edge and returns on the falling edge
    // after it has been taken. The word is held steady while the block stalls, and
    // valid is left high so that back-to-back words need no gap between them.
    task automatic send_vertex(input in_word_t w);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_vertex(w);
        accepted++;
        // The sender and the receiver swap their idling rates after the first
        // third of the run, and in the last third neither side idles at all.
        if (accepted == MODE_SPLIT)
        begin
            send_gap_pct   = 46;
            recv_stall_pct = 38;
        end
        else if (accepted == 2 * MODE_SPLIT)
        begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
        end
        @(negedge clk);
    endtask

    // Lowers valid and waits until every predicted triangle has come out, then
    // waits on in case a first-row vertex, which leaves nothing, is still on its
    // way through the job queue. Returns on a falling edge.
    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Writes the row width register once the block has gone idle.
    task automatic write_width(input logic [CFG_W-1:0] setting);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= setting;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        tracker.set_width(setting);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One phase of random traffic at one row width setting. The first word starts
    // a new mesh unless every row-store entry the new width can read has already
    // been written, in which case the current mesh may carry on across the change.
    // After that, mesh_start is raised only now and then, which breaks rows off
    // part-way and restarts the lattice.
    task automatic run_phase(input logic [CFG_W-1:0] setting, input int unsigned count,
                             input int unsigned noise_pct);
        in_word_t    w;
        bit          rows_ready;
        int unsigned wd;
        write_width(setting);
        wd         = tracker.eff_width();
        rows_ready = 1'b1;
        for (int unsigned k = 0; k < wd; k++)
        begin
            if (!tracker.written[k])
                rows_ready = 1'b0;
        end
        for (int unsigned n = 0; n < count; n++)
        begin
            if (n == 0)
                w.mesh_start = !(rows_ready && ($urandom_range(1) == 1));
            else
                w.mesh_start = ($urandom_range(99) < noise_pct);
            w.vertex_x     = pick_word();
            w.vertex_y     = pick_word();
            w.vertex_color = pick_word();
            send_vertex(w);
        end
    endtask

    initial
    begin
        tracker        = new();
        cycles         = 0;
        accepted       = 0;
        send_gap_pct   = 38;
        recv_stall_pct = 46;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_word        = '0;
        out_stall      = 1'b0;
        repeat (2)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Width setting 0 acts as 2. The second row pairs the corner values of the
        // first: column 0 yields only the up-right triangle, column 1 (the last)
        // only the left-neighbour one, each flagged as the last of its vertex.
        write_width(11'd0);
        send_vertex(vtx(1'b1, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000));
        send_vertex(vtx(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff));
        send_vertex(vtx(1'b0, 32'h0000_0000, 32'hffff_ffff, 32'ha5a5_a5a5));
        send_vertex(vtx(1'b0, 32'hffff_ffff, 32'h0000_0000, 32'h5a5a_5a5a));
        // A mesh start at column 0 throws the stored row away; this row only fills.
        send_vertex(vtx(1'b1, 32'h0000_0001, 32'hffff_fffe, 32'h0000_0001));
        send_vertex(vtx(1'b0, 32'h8000_0001, 32'h7fff_fffe, 32'hffff_fffe));

        // Five columns, with a mesh start in the middle of the second row. The run
        // stops four columns into the following second row.
        write_width(11'd5);
        for (int n = 0; n < 16; n++)
            send_vertex(vtx((n == 0) || (n == 7), pick_word(), pick_word(), pick_word()));

        // The width shrinks under the half-finished row: the next vertex sits
        // beyond the new last column and is taken as that column, and the row
        // after it starts afresh at column 0.
        write_width(11'd3);
        for (int n = 0; n < 3; n++)
            send_vertex(vtx(1'b0, pick_word(), pick_word(), pick_word()));

        // Random phases over a spread of widths, the clipped ones among them.
        // The widest row runs without restarts so that its first row completes,
        // which leaves the whole row store written for the phase after it.
        run_phase(11'd1, $urandom_range(55, 90), 3);
        run_phase(11'd4, $urandom_range(55, 90), 3);
        run_phase(11'd7, $urandom_range(55, 90), 3);
        run_phase(11'd2, $urandom_range(55, 90), 3);
        run_phase(11'd16, $urandom_range(55, 90), 3);
        run_phase(11'd1024, MAX_ROW_VERTICES + 30, 0);
        run_phase(11'd2047, 24, 0);
        run_phase(11'd3, $urandom_range(55, 90), 3);
        run_phase(11'd11, $urandom_range(55, 90), 3);
        run_phase(11'd0, $urandom_range(55, 90), 3);
        run_phase(11'd5, $urandom_range(55, 90), 3);

        drain();
        if ((tracker.errors == 0) && (tracker.pending() == 0))
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
